/* hdl/bpg_pkg.sv */
package bpg_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 256;
   localparam int PHASE_BITS_DEFAULT = 16;

   localparam int WIDTH_BITS = 9;
   localparam int NUM_BITS   = 17;
   localparam int CSR_BITS   = 3;

   localparam logic [1:0] BG_SOLID    = 2'd0;
   localparam logic [1:0] BG_GRADIENT = 2'd1;
   localparam logic [1:0] BG_RAINBOW  = 2'd2;

   localparam logic ITEM_FRAME = 1'b0;
   localparam logic ITEM_PIXEL = 1'b1;

   localparam logic [CSR_BITS-1:0] CSR_MODE   = 3'd0;
   localparam logic [CSR_BITS-1:0] CSR_COLOR1 = 3'd1;
   localparam logic [CSR_BITS-1:0] CSR_COLOR2 = 3'd2;
   localparam logic [CSR_BITS-1:0] CSR_WIDTH  = 3'd3;
   localparam logic [CSR_BITS-1:0] CSR_SPEED  = 3'd4;

   localparam logic [1:0] CHAN_RED   = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_BLUE  = 2'd2;

   typedef struct packed {
      logic       load_item;
      logic       mul_en;
      logic       phase_en;
      logic       div_start;
      logic [1:0] chan_sel;
      logic       chan_store;
      logic       hue_en;
      logic       out_load;
   } bpg_cmd_type;

   typedef struct packed {
      logic       is_pixel;
      logic [1:0] bg_mode;
      logic       wide;
      logic       div_done;
   } bpg_status_type;

endpackage

/* hdl/bpg_divider.sv */
module bpg_divider #(
   parameter int DIV_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 short_op,
   input  logic [DIV_BITS-1:0]                  dividend,
   input  logic [bpg_pkg::WIDTH_BITS-1:0]       divisor,
   output logic [DIV_BITS-1:0]                  quotient,
   output logic                                 done
);
   import bpg_pkg::*;

   localparam int CW          = $clog2(DIV_BITS + 1);
   localparam int SHORT_SHIFT = DIV_BITS - NUM_BITS;

   logic [DIV_BITS-1:0]   q_ff, q_in;
   logic [WIDTH_BITS-1:0] rem_ff, rem_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [WIDTH_BITS-1:0] div_ff, div_in;
   logic [WIDTH_BITS:0]   shifted;
   logic                  ge;

   assign shifted = {rem_ff, q_ff[DIV_BITS-1]};
   assign ge      = shifted >= {1'b0, div_ff};

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      if (start) begin
         q_in   = short_op ? (dividend << SHORT_SHIFT) : dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = short_op ? CW'(NUM_BITS) : CW'(DIV_BITS);
      end else if (cnt_ff != '0) begin
         if (ge) begin
            rem_in = WIDTH_BITS'(shifted - {1'b0, div_ff});
            q_in   = {q_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[WIDTH_BITS-1:0];
            q_in   = {q_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient = q_ff;
   assign done     = done_ff;

endmodule

/* hdl/bpg_datapath.sv */
module bpg_datapath #(
   parameter int MAX_WIDTH  = bpg_pkg::MAX_WIDTH_DEFAULT,
   parameter int PHASE_BITS = bpg_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [bpg_pkg::CSR_BITS-1:0]      csr_addr,
   input  logic [31:0]                       csr_wdata,
   input  logic                              req_tuser,
   input  logic [23:0]                       req_tdata,
   input  bpg_pkg::bpg_cmd_type              cmd,
   output bpg_pkg::bpg_status_type           status,
   output logic [31:0]                       rsp_tdata
);
   import bpg_pkg::*;

   localparam int DIV_BITS = (PHASE_BITS + 8 > NUM_BITS) ? PHASE_BITS + 8 : NUM_BITS;
   localparam int WCAP     = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
   localparam logic [WIDTH_BITS-1:0] WCAP_W = WIDTH_BITS'(WCAP);
   localparam int SW = PHASE_BITS + 3;
   localparam int UW = PHASE_BITS + 8;

   localparam logic [2:0] SECTOR_0 = 3'd0;
   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;

   logic [1:0]             mode_ff;
   logic [31:0]            color1_ff;
   logic [23:0]            color2_ff;
   logic [WIDTH_BITS-1:0]  width_ff;
   logic [15:0]            speed_ff;
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;

   logic                   pix_ff;
   logic [7:0]             x_ff;
   logic [15:0]            dt_ff;
   logic signed [32:0]     prod_ff;
   logic [7:0]             grad_r_ff, grad_g_ff, grad_b_ff;
   logic [PHASE_BITS-1:0]  hue_ff;
   logic [31:0]            rsp_ff, rsp_in;

   logic [WIDTH_BITS-1:0]  width_eff, span;
   logic [7:0]             x_in;
   logic [33+PHASE_BITS-1:0] prod_sh;
   logic [PHASE_BITS-1:0]  step;
   logic [7:0]             a_ch, b_ch;
   logic [NUM_BITS-1:0]    num;
   logic                   rainbow_op;
   logic [DIV_BITS-1:0]    dividend, quotient;
   logic [WIDTH_BITS-1:0]  divisor;
   logic                   div_done;
   logic [SW-1:0]          s_val;
   logic [2:0]             sector;
   logic [PHASE_BITS-1:0]  frac, nfrac;
   logic [UW-1:0]          up_full, down_full;
   logic [7:0]             up, down, hr, hg, hb;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= BG_SOLID;
         color1_ff <= 32'd255;
         color2_ff <= 24'd0;
         width_ff  <= 9'd16;
         speed_ff  <= 16'd256;
         phase_ff  <= '0;
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               CSR_MODE:   mode_ff   <= csr_wdata[1:0];
               CSR_COLOR1: color1_ff <= csr_wdata;
               CSR_COLOR2: color2_ff <= csr_wdata[23:0];
               CSR_WIDTH:  width_ff  <= csr_wdata[WIDTH_BITS-1:0];
               CSR_SPEED:  speed_ff  <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (cmd.phase_en) begin
            phase_ff <= phase_in;
         end
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         width_eff = WIDTH_BITS'(1);
      end else if (width_ff > WCAP_W) begin
         width_eff = WCAP_W;
      end else begin
         width_eff = width_ff;
      end
   end

   assign span = width_eff - 1'b1;
   assign x_in = ({1'b0, req_tdata[7:0]} > span) ? span[7:0] : req_tdata[7:0];

   assign prod_sh  = {prod_ff, {PHASE_BITS{1'b0}}};
   assign step     = prod_sh[PHASE_BITS+19:20];
   assign phase_in = phase_ff + step;

   always_comb begin
      case (cmd.chan_sel)
         CHAN_RED: begin
            a_ch = color1_ff[31:24];
            b_ch = color2_ff[23:16];
         end
         CHAN_GREEN: begin
            a_ch = color1_ff[23:16];
            b_ch = color2_ff[15:8];
         end
         default: begin
            a_ch = color1_ff[15:8];
            b_ch = color2_ff[7:0];
         end
      endcase
   end

   assign num = ({9'd0, a_ch} * {8'd0, span - {1'b0, x_ff}})
              + ({9'd0, b_ch} * {9'd0, x_ff});

   assign rainbow_op = (mode_ff == BG_RAINBOW);
   assign dividend   = rainbow_op ? DIV_BITS'({x_ff, {PHASE_BITS{1'b0}}}) : DIV_BITS'(num);
   assign divisor    = rainbow_op ? width_eff : span;

   bpg_divider #(
      .DIV_BITS(DIV_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .short_op (!rainbow_op),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         pix_ff <= req_tuser;
         x_ff   <= x_in;
         dt_ff  <= req_tdata[23:8];
      end
      if (cmd.mul_en) begin
         prod_ff <= $signed(speed_ff) * $signed({1'b0, dt_ff});
      end
      if (cmd.chan_store) begin
         case (cmd.chan_sel)
            CHAN_RED:   grad_r_ff <= quotient[7:0];
            CHAN_GREEN: grad_g_ff <= quotient[7:0];
            default:    grad_b_ff <= quotient[7:0];
         endcase
      end
      if (cmd.hue_en) begin
         hue_ff <= phase_ff + quotient[PHASE_BITS-1:0];
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign s_val     = SW'({hue_ff, 2'b00}) + SW'({hue_ff, 1'b0});
   assign sector    = s_val[SW-1:PHASE_BITS];
   assign frac      = s_val[PHASE_BITS-1:0];
   assign nfrac     = ~frac;
   assign up_full   = {frac, 8'd0} - UW'(frac);
   assign down_full = {nfrac, 8'd0} - UW'(nfrac);
   assign up        = up_full[UW-1:PHASE_BITS];
   assign down      = down_full[UW-1:PHASE_BITS];

   always_comb begin
      case (sector)
         SECTOR_0: begin hr = 8'd255; hg = up;     hb = 8'd0;   end
         SECTOR_1: begin hr = down;   hg = 8'd255; hb = 8'd0;   end
         SECTOR_2: begin hr = 8'd0;   hg = 8'd255; hb = up;     end
         SECTOR_3: begin hr = 8'd0;   hg = down;   hb = 8'd255; end
         SECTOR_4: begin hr = up;     hg = 8'd0;   hb = 8'd255; end
         default:  begin hr = 8'd255; hg = 8'd0;   hb = down;   end
      endcase
   end

   always_comb begin
      case (mode_ff)
         BG_GRADIENT: begin
            if (span != '0) begin
               rsp_in = {8'd255, grad_b_ff, grad_g_ff, grad_r_ff};
            end else begin
               rsp_in = {8'd255, color1_ff[15:8], color1_ff[23:16], color1_ff[31:24]};
            end
         end
         BG_RAINBOW: rsp_in = {8'd255, hb, hg, hr};
         default: rsp_in = {color1_ff[7:0], color1_ff[15:8], color1_ff[23:16],
                            color1_ff[31:24]};
      endcase
   end

   assign status.is_pixel = (pix_ff == ITEM_PIXEL);
   assign status.bg_mode  = mode_ff;
   assign status.wide     = (span != '0);
   assign status.div_done = div_done;
   assign rsp_tdata       = rsp_ff;

endmodule

/* hdl/bpg_controller.sv */
module bpg_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  bpg_pkg::bpg_status_type  status,
   output bpg_pkg::bpg_cmd_type     cmd
);
   import bpg_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_ADD    = 3'd3;
   localparam logic [2:0] ST_LOAD   = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] chan_ff, chan_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      cmd      = '0;
      cmd.chan_sel = chan_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            chan_in = CHAN_RED;
            if (!status.is_pixel) begin
               state_in = (status.bg_mode == BG_RAINBOW) ? ST_MUL : ST_IDLE;
            end else if (status.bg_mode == BG_RAINBOW ||
                         (status.bg_mode == BG_GRADIENT && status.wide)) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_ADD;
         end
         ST_ADD: begin
            cmd.phase_en = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               if (status.bg_mode == BG_RAINBOW) begin
                  cmd.hue_en = 1'b1;
                  state_in   = ST_OUT;
               end else begin
                  cmd.chan_store = 1'b1;
                  if (chan_ff == CHAN_BLUE) begin
                     state_in = ST_OUT;
                  end else begin
                     chan_in  = chan_ff + 1'b1;
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= CHAN_RED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/background_pattern_pixel_generator.sv */
// One item at a time. Frame tick: decode, and in rainbow mode multiply, then phase add.
// Solid pixel, or gradient with width 1: decode, then the result register loads once the
// output is free. Rainbow pixel: one bit-serial division (DIV_BITS steps, x*2^PHASE_BITS/W).
// Gradient pixel: three 17-step divisions on the same divider.
// The output register lets the next item enter while a result waits.
// Synchronous active-high reset: CSR registers to defaults, phase zero, no result pending.
module background_pattern_pixel_generator #(
   parameter int MAX_WIDTH  = bpg_pkg::MAX_WIDTH_DEFAULT,
   parameter int PHASE_BITS = bpg_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,  // column[7:0], frame_dt[23:8]
   input  logic                          req_tuser,  // item kind, 0 frame tick, 1 pixel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
   input  logic                          csr_wen,
   input  logic [bpg_pkg::CSR_BITS-1:0]  csr_addr,
   input  logic [31:0]                   csr_wdata
);
   import bpg_pkg::*;

   bpg_cmd_type    cmd;
   bpg_status_type status;

   bpg_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bpg_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PHASE_BITS (PHASE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

/* hdl/bpg_checker.sv */
module bpg_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          req_tuser,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [31:0]                   rsp_tdata
);
   import bpg_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in work");

   a_frame_no_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ITEM_FRAME && !rsp_tvalid |=> !rsp_tvalid)
      else $error("frame tick produced a result");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset did not return to idle");

endmodule

bind background_pattern_pixel_generator bpg_checker u_bpg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
